FILE: hdl/sequential_list_engine_top_defines.svh
// Assertion macros for the sequential list engine.
// Uses the clk and rst_n names of the module that includes it.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH

// check an expression at every clock edge out of reset
`define SLE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check a consequence in the same cycle
`define SLE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the next cycle
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sle_pkg.sv
// Shared types and constants of the sequential list engine.
// No dependencies.
package sle_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 6;
    localparam int CNT_W    = 7;
    localparam int SCAN_W   = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_FIND   = 3'd2,
        KIND_PUSH   = 3'd3,
        KIND_POP    = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic ins;
        logic ers;
    } cell_op_t;

endpackage

FILE: hdl/sequential_list_engine_top.sv
// Top level of the sequential list engine: request decode, chain of storage cells,
// find scan and result register. Depends on sle_pkg, sle_cell and the defines header.
`include "sequential_list_engine_top_defines.svh"

// Bounded ordered list of up to CAPACITY entries. Insert and push back move the
// entries from the position up one cell higher and put the value at the position;
// erase moves those above it one cell lower; pop back only lowers the count. Find
// compares all cells at once, then scans the match flags eight per cycle, ending at
// the first hit or the last chunk. A new request is taken once the previous one has
// left its result in the output register and that register is free or being drained.
// The entry store has no reset; only entries below the count are ever read.
module sequential_list_engine_top #(
    parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // kind[2:0], position[9:3], value[41:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // status[1:0], found_index[7:2], count[14:8], zero pad
);

    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;
    localparam int NCH     = (CAPACITY + sle_pkg::SCAN_W - 1) / sle_pkg::SCAN_W;
    localparam int CHUNK_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IX_W    = CHUNK_W + $clog2(sle_pkg::SCAN_W);
    localparam int OFF_W   = $clog2(sle_pkg::SCAN_W);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CHUNK_W-1:0]          chunk_reg, chunk_next;
    logic [NCH-1:0][sle_pkg::SCAN_W-1:0] hit_reg, hit_next;
    logic                        m_tvalid_reg;
    sle_pkg::status_t            status_reg, status_next;
    logic [sle_pkg::FIDX_W-1:0]  fidx_reg, fidx_next;
    logic [sle_pkg::CNT_W-1:0]   cnt_out_reg, cnt_out_next;
    logic                        load_out;

    sle_pkg::kind_t              kind;
    logic [sle_pkg::POS_W-1:0]   position;
    logic [sle_pkg::VAL_W-1:0]   value;
    logic [DATA_WIDTH+sle_pkg::VAL_W-1:0] value_wide;
    logic [DATA_WIDTH-1:0]       value_st;
    logic [CMP_W-1:0]            pos_ext, cnt_ext, cell_pos;
    logic                        accept, full;
    sle_pkg::cell_op_t           op;

    logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_data;
    logic [CAPACITY-1:0]                 cell_match;
    logic [NCH*sle_pkg::SCAN_W-1:0]      match_flat;

    logic [sle_pkg::SCAN_W-1:0]  chunk_bits;
    logic [OFF_W-1:0]            off;
    logic [IX_W-1:0]             hit_idx;
    logic [IX_W+sle_pkg::FIDX_W-1:0] hit_wide;
    logic [CW+sle_pkg::CNT_W-1:0]    cnt_wide;

    assign kind       = sle_pkg::kind_t'(s_tdata[2:0]);
    assign position   = s_tdata[9:3];
    assign value      = s_tdata[41:10];
    assign value_wide = {{DATA_WIDTH{1'b0}}, value};
    assign value_st   = value_wide[DATA_WIDTH-1:0];
    assign pos_ext    = CMP_W'(position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign full       = (count_reg == CW'(CAPACITY));
    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] lo_d, hi_d;
            if (gi == 0)
            begin : g_first
                assign lo_d = value_st;
            end
            else
            begin : g_mid_lo
                assign lo_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign hi_d = cell_data[gi];
            end
            else
            begin : g_mid_hi
                assign hi_d = cell_data[gi+1];
            end

            sle_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CMP_W      (CMP_W),
                .IDX        (gi)
            ) u_cell (
                .clk     (clk),
                .op      (op),
                .pos     (cell_pos),
                .value   (value_st),
                .lo_data (lo_d),
                .hi_data (hi_d),
                .data    (cell_data[gi]),
                .match   (cell_match[gi])
            );

            assign match_flat[gi] = cell_match[gi] && (CMP_W'(gi) < cnt_ext);
        end
        for (gi = CAPACITY; gi < NCH * sle_pkg::SCAN_W; gi++)
        begin : g_pad
            assign match_flat[gi] = 1'b0;
        end
    endgenerate

    assign chunk_bits = hit_reg[chunk_reg];

    always_comb
    begin
        off = '0;
        for (int i = sle_pkg::SCAN_W - 1; i >= 0; i--)
        begin
            if (chunk_bits[i])
            begin
                off = OFF_W'(i);
            end
        end
    end

    assign hit_idx  = {chunk_reg, off};
    assign hit_wide = {{sle_pkg::FIDX_W{1'b0}}, hit_idx};
    assign cnt_wide = {{sle_pkg::CNT_W{1'b0}}, count_next};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        chunk_next  = chunk_reg;
        hit_next    = hit_reg;
        op          = '0;
        cell_pos    = pos_ext;
        load_out    = 1'b0;
        status_next = sle_pkg::ST_BAD;
        fidx_next   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (kind)
                        sle_pkg::KIND_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                status_next = sle_pkg::ST_BAD;
                            end
                            else if (full)
                            begin
                                status_next = sle_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = sle_pkg::ST_OK;
                                op.ins      = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        sle_pkg::KIND_ERASE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = sle_pkg::ST_BAD;
                            end
                            else
                            begin
                                status_next = sle_pkg::ST_OK;
                                op.ers      = 1'b1;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        sle_pkg::KIND_FIND:
                        begin
                            load_out   = 1'b0;
                            state_next = S_SCAN;
                            chunk_next = '0;
                            hit_next   = match_flat;
                        end
                        sle_pkg::KIND_PUSH:
                        begin
                            cell_pos = cnt_ext;
                            if (full)
                            begin
                                status_next = sle_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = sle_pkg::ST_OK;
                                op.ins      = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        sle_pkg::KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sle_pkg::ST_BAD;
                            end
                            else
                            begin
                                status_next = sle_pkg::ST_OK;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = sle_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if ((|chunk_bits) || (chunk_reg == CHUNK_W'(NCH - 1)))
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (|chunk_bits)
                    begin
                        status_next = sle_pkg::ST_OK;
                        fidx_next   = hit_wide[sle_pkg::FIDX_W-1:0];
                    end
                    else
                    begin
                        status_next = sle_pkg::ST_MISSING;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cnt_out_next = cnt_wide[sle_pkg::CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            chunk_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            chunk_reg <= chunk_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        if (load_out)
        begin
            status_reg  <= status_next;
            fidx_reg    <= fidx_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, cnt_out_reg, fidx_reg, status_reg};

    `SLE_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "count above capacity")
    `SLE_ASSERT_NEXT(a_find_scans, accept && kind == sle_pkg::KIND_FIND, state_reg == S_SCAN, "find did not start scan")
    `SLE_ASSERT_IMPL(a_scan_out_free, state_reg == S_SCAN, !m_tvalid_reg, "result pending during scan")
    `SLE_ASSERT_NEXT(a_direct_result, accept && kind != sle_pkg::KIND_FIND, m_tvalid_reg && state_reg == S_IDLE, "missing result beat")

endmodule

FILE: hdl/sle_cell.sv
// One storage cell of the list chain: holds an entry, shifts with its neighbors,
// compares against the search value. Depends on sle_pkg.
module sle_cell #(
    parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF,
    parameter int CMP_W      = sle_pkg::POS_W,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  sle_pkg::cell_op_t     op,
    input  logic [CMP_W-1:0]      pos,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] lo_data,
    input  logic [DATA_WIDTH-1:0] hi_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            if (MY_IDX > pos)
            begin
                data_next = lo_data;
            end
            else if (MY_IDX == pos)
            begin
                data_next = value;
            end
        end
        else if (op.ers)
        begin
            if (MY_IDX >= pos)
            begin
                data_next = hi_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == value);

endmodule

FILE: bench/sequential_list_engine_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sequential_list_engine_top: streams list requests, keeps a local
// copy of the list to predict result beats, uses the table's result for typed directed rows
// and compares each beat field by field. Depends on sle_pkg and the engine RTL.
module sequential_list_engine_top_tb;
    import sle_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_ITEMS   = 12;
    localparam int MIXED_ITEMS  = 50;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } list_request_t;

    typedef struct packed {
        status_t           status;
        logic [FIDX_W-1:0] found_index;
        logic [CNT_W-1:0]  count;
    } list_result_t;

    typedef struct packed {
        list_request_t request;
        logic          typed;
        list_result_t  result;
    } directed_row_t;

    typedef enum int {
        MODE_GROW,
        MODE_HOLD_FULL,
        MODE_SHRINK,
        MODE_MIXED
    } list_mode_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [VAL_W-1:0] list_store [LIST_DEPTH];
    int               list_count = 0;
    list_result_t     pending_results [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;

    directed_row_t directed_rows [25] = '{
        '{'{KIND_POP,       7'd0,   32'd0},           1'b1, '{ST_BAD,     6'd0, 7'd0}},
        '{'{KIND_ERASE,     7'd0,   32'd0},           1'b1, '{ST_BAD,     6'd0, 7'd0}},
        '{'{KIND_FIND,      7'd0,   32'd0},           1'b1, '{ST_MISSING, 6'd0, 7'd0}},
        '{'{KIND_INSERT,    7'd1,   32'd1},           1'b1, '{ST_BAD,     6'd0, 7'd0}},
        '{'{KIND_INSERT,    7'd0,   32'h7FFF_FFFF},   1'b1, '{ST_OK,      6'd0, 7'd1}},
        '{'{KIND_PUSH,      7'd0,   32'h8000_0000},   1'b1, '{ST_OK,      6'd0, 7'd2}},
        '{'{KIND_PUSH,      7'd127, 32'd0},           1'b1, '{ST_OK,      6'd0, 7'd3}},
        '{'{KIND_PUSH,      7'd0,   32'hFFFF_FFFF},   1'b1, '{ST_OK,      6'd0, 7'd4}},
        '{'{KIND_INSERT,    7'd4,   32'd5},           1'b0, '0},
        '{'{KIND_INSERT,    7'd2,   32'd5},           1'b0, '0},
        '{'{KIND_FIND,      7'd0,   32'd5},           1'b0, '0},
        '{'{KIND_FIND,      7'd0,   32'hFFFF_FFFF},   1'b0, '0},
        '{'{KIND_FIND,      7'd0,   32'h1234_5678},   1'b0, '0},
        '{'{KIND_INSERT,    7'd127, 32'd9},           1'b1, '{ST_BAD,     6'd0, 7'd6}},
        '{'{KIND_INSERT,    7'd7,   32'd9},           1'b1, '{ST_BAD,     6'd0, 7'd6}},
        '{'{KIND_ERASE,     7'd64,  32'd0},           1'b1, '{ST_BAD,     6'd0, 7'd6}},
        '{'{KIND_ERASE,     7'd6,   32'd0},           1'b1, '{ST_BAD,     6'd0, 7'd6}},
        '{'{KIND_UNUSED_LO, 7'd0,   32'd0},           1'b1, '{ST_BAD,     6'd0, 7'd6}},
        '{'{KIND_UNUSED_HI, 7'd127, 32'hFFFF_FFFF},   1'b1, '{ST_BAD,     6'd0, 7'd6}},
        '{'{KIND_ERASE,     7'd0,   32'd0},           1'b0, '0},
        '{'{KIND_ERASE,     7'd4,   32'd0},           1'b0, '0},
        '{'{KIND_INSERT,    7'd0,   32'h8000_0000},   1'b0, '0},
        '{'{KIND_POP,       7'd0,   32'd0},           1'b0, '0},
        '{'{KIND_FIND,      7'd0,   32'h7FFF_FFFF},   1'b0, '0},
        '{'{KIND_ERASE,     7'd1,   32'd0},           1'b0, '0}
    };

    sequential_list_engine_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic status_t place_entry(int pos, logic [VAL_W-1:0] value);
        if (pos > list_count)
            return ST_BAD;
        if (list_count >= LIST_DEPTH)
            return ST_FULL;
        for (int i = list_count; i > pos; i--)
            list_store[i] = list_store[i-1];
        list_store[pos] = value;
        list_count++;
        return ST_OK;
    endfunction

    function automatic status_t remove_entry(int pos);
        if (pos >= list_count)
            return ST_BAD;
        for (int i = pos; i + 1 < list_count; i++)
            list_store[i] = list_store[i+1];
        list_count--;
        return ST_OK;
    endfunction

    function automatic list_result_t predict_list_result(list_request_t req);
        list_result_t res;
        res.status = ST_BAD;
        res.found_index = '0;
        case (req.kind)
            KIND_INSERT: res.status = place_entry(int'(req.position), req.value);
            KIND_ERASE:  res.status = remove_entry(int'(req.position));
            KIND_FIND:
            begin
                res.status = ST_MISSING;
                for (int i = 0; i < list_count; i++)
                begin
                    if (list_store[i] == req.value)
                    begin
                        res.status = ST_OK;
                        res.found_index = FIDX_W'(i);
                        break;
                    end
                end
            end
            KIND_PUSH:   res.status = place_entry(list_count, req.value);
            KIND_POP:    res.status = (list_count == 0) ? ST_BAD : remove_entry(list_count - 1);
            default:     res.status = ST_BAD;
        endcase
        res.count = CNT_W'(list_count);
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] draw_value();
        case ($urandom_range(3))
            0, 1: return $urandom;
            2:    return $urandom_range(7);
            default:
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] draw_find_value();
        if (list_count > 0 && $urandom_range(3) != 0)
            return list_store[$urandom_range(list_count - 1)];
        return draw_value();
    endfunction

    function automatic list_request_t draw_list_request(list_mode_t mode);
        list_request_t req;
        int roll;
        roll = $urandom_range(99);
        req.kind = KIND_W'($urandom_range(7));
        req.position = POS_W'($urandom_range(127));
        req.value = draw_value();
        case (mode)
            MODE_GROW:
            begin
                if (roll < 50)
                    req.kind = KIND_PUSH;
                else if (roll < 80)
                begin
                    req.kind = KIND_INSERT;
                    req.position = POS_W'($urandom_range(list_count));
                end
                else if (roll < 88)
                begin
                    req.kind = KIND_FIND;
                    req.value = draw_find_value();
                end
                else if (roll < 94)
                    req.kind = KIND_POP;
            end
            MODE_HOLD_FULL:
            begin
                if (roll < 40)
                    req.kind = KIND_PUSH;
                else if (roll < 70)
                    req.kind = KIND_INSERT;
                else if (roll < 85)
                begin
                    req.kind = KIND_FIND;
                    req.value = draw_find_value();
                end
            end
            MODE_SHRINK:
            begin
                if (roll < 40)
                    req.kind = KIND_POP;
                else if (roll < 75)
                begin
                    req.kind = KIND_ERASE;
                    req.position = (list_count > 0) ?
                                   POS_W'($urandom_range(list_count - 1)) : '0;
                end
                else if (roll < 90)
                begin
                    req.kind = KIND_FIND;
                    req.value = draw_find_value();
                end
                else if (roll < 95)
                    req.kind = KIND_PUSH;
            end
            default:
            begin
                if (roll < 20)
                    req.kind = KIND_PUSH;
                else if (roll < 40)
                begin
                    req.kind = KIND_INSERT;
                    req.position = POS_W'($urandom_range(list_count));
                end
                else if (roll < 55)
                begin
                    req.kind = KIND_ERASE;
                    req.position = POS_W'($urandom_range(list_count));
                end
                else if (roll < 70)
                    req.kind = KIND_POP;
                else if (roll < 90)
                begin
                    req.kind = KIND_FIND;
                    req.value = draw_find_value();
                end
            end
        endcase
        return req;
    endfunction

    task automatic send_list_request(input list_request_t req, input logic typed,
                                     input list_result_t typed_result);
        list_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, req.value, req.position, req.kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_list_result(req);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic check_list_result(input logic [15:0] beat);
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result beat %h with no request outstanding", beat);
            mismatch_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (beat[1:0] !== want.status)
            begin
                $error("status expected %0d got %0d", want.status, beat[1:0]);
                mismatch_count++;
            end
            if (beat[7:2] !== want.found_index)
            begin
                $error("found_index expected %0d got %0d", want.found_index, beat[7:2]);
                mismatch_count++;
            end
            if (beat[14:8] !== want.count)
            begin
                $error("count expected %0d got %0d", want.count, beat[14:8]);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            check_list_result(m_tdata);
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        list_mode_t mode;
        int mode_items;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle_pct = 14;
        receiver_stall_pct = 53;
        foreach (directed_rows[i])
            send_list_request(directed_rows[i].request, directed_rows[i].typed,
                              directed_rows[i].result);
        mode = MODE_GROW;
        mode_items = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 53;
                receiver_stall_pct = 14;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            send_list_request(draw_list_request(mode), 1'b0, '0);
            mode_items++;
            case (mode)
                MODE_GROW:
                    if (list_count == LIST_DEPTH)
                    begin
                        mode = MODE_HOLD_FULL;
                        mode_items = 0;
                    end
                MODE_HOLD_FULL:
                    if (mode_items >= HOLD_ITEMS)
                    begin
                        mode = MODE_SHRINK;
                        mode_items = 0;
                    end
                MODE_SHRINK:
                    if (list_count == 0)
                    begin
                        mode = MODE_MIXED;
                        mode_items = 0;
                    end
                default:
                    if (mode_items >= MIXED_ITEMS)
                    begin
                        mode = MODE_GROW;
                        mode_items = 0;
                    end
            endcase
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
